// ----- sv/mpf_pkg.sv -----
// Shared types, codes and helpers for the multilevel priority FIFO.
package mpf_pkg;

    // Field widths of the request and result items
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned IN_ID_W  = 8;
    localparam int unsigned OUT_ID_W = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LEVEL,
        S_SLOT,
        S_HOLD
    } t_state;

    // Pack one result item, first field in the lowest bits
    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [OUT_ID_W-1:0] id,
        input logic [LEVEL_W-1:0]  level,
        input t_status             status
    );
        pack_result = {2'b00, status, level, id};
    endfunction

endpackage

// ----- sv/multilevel_priority_fifo.sv -----
// Multilevel priority FIFO: per-level FIFOs kept in a slot memory and a level-state memory.
//
// Request channel (s_axis): one command per request: push an id into the FIFO of a
// level, pop the head of the most urgent non-empty level (level 0 first), or peek it.
// Result channel (m_axis): exactly one result per request, in request order, carrying
// the popped or peeked id, its level and a status (ok, empty, full).
// Timing: a request is taken only while the sequencer is idle. A push runs a level-state
// read, then the slot and level-state write; a pop or peek runs a level-state read, a
// slot read, then the result; a request that needs no memory access goes straight to
// the result. The level-state memory and the slot memory both have registered reads.
// The result sits in an output register; the next request is accepted while it waits.
// If the receiver stalls, a finished result is parked until the output register frees,
// and no further request is taken meanwhile.
// Reset clears the non-empty flags of all levels, so every level starts empty at once;
// the memories need no clearing pass. A push into a full level is dropped with status
// full; pop or peek with all levels empty returns status empty; command 3 returns ok.
module multilevel_priority_fifo #(
    parameter int unsigned NUM_LEVELS  = 16,
    parameter int unsigned LEVEL_DEPTH = 16,
    parameter int unsigned ID_WIDTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // cmd[1:0], level[5:2], entry_id[13:6], zero[15:14]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // out_id[7:0], out_level[11:8], status[13:12], zero[15:14]
);

    localparam int unsigned LVL_W  = $clog2(NUM_LEVELS);
    localparam int unsigned PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned ENT_W  = 2 * PTR_W + CNT_W;
    localparam int unsigned SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int unsigned ADDR_W = $clog2(SLOTS);

    // Request fields
    mpf_pkg::t_cmd                 w_in_cmd;
    logic [mpf_pkg::LEVEL_W-1:0]   w_in_level;
    logic [mpf_pkg::IN_ID_W-1:0]   w_in_id;
    logic [LVL_W-1:0]              w_push_lvl;
    logic                          w_s_accept;

    // Sequencer and captured request
    mpf_pkg::t_state               r_state, n_state;
    mpf_pkg::t_cmd                 r_cmd;
    logic [LVL_W-1:0]              r_lvl;
    logic [ID_WIDTH-1:0]           r_id;
    mpf_pkg::t_status              r_hold_status;

    // Non-empty flags and priority encode
    logic [NUM_LEVELS-1:0]         r_nonempty;
    logic [LVL_W-1:0]              w_busy_lvl;
    logic                          w_any;
    logic                          w_flag_set;
    logic                          w_flag_clr;

    // Level-state memory: {head, tail, count} per level
    logic [ENT_W-1:0]              r_lvl_mem [NUM_LEVELS];
    logic [ENT_W-1:0]              r_lvl_q;
    logic                          w_lvl_rd_en;
    logic [LVL_W-1:0]              w_lvl_rd_addr;
    logic                          w_lvl_wr_en;
    logic [ENT_W-1:0]              w_lvl_wr_data;
    logic [ENT_W-1:0]              w_ent;
    logic [PTR_W-1:0]              w_head;
    logic [PTR_W-1:0]              w_tail;
    logic [CNT_W-1:0]              w_count;
    logic [PTR_W-1:0]              w_head_nxt;
    logic [PTR_W-1:0]              w_tail_nxt;

    // Slot memory
    logic [ID_WIDTH-1:0]           r_slot_mem [SLOTS];
    logic [ID_WIDTH-1:0]           r_slot_q;
    logic                          w_slot_wr_en;
    logic                          w_slot_rd_en;
    logic [ADDR_W-1:0]             w_slot_addr;

    // Output register
    logic                          r_out_valid;
    logic [mpf_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [mpf_pkg::OUT_DATA_W-1:0] w_out_data;
    logic                          w_hold_load;
    mpf_pkg::t_status              w_hold_status;

    // Unpack the request
    assign w_in_cmd   = mpf_pkg::t_cmd'(i_s_tdata[1:0]);
    assign w_in_level = i_s_tdata[5:2];
    assign w_in_id    = i_s_tdata[13:6];
    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == mpf_pkg::S_IDLE);

    // Saturate the push level to the last level
    assign w_push_lvl = (32'(w_in_level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                        : LVL_W'(w_in_level);

    // Find the most urgent non-empty level
    always_comb begin
        w_busy_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                w_busy_lvl = LVL_W'(i);
            end
        end
    end
    assign w_any = |r_nonempty;

    // Level state; an empty level reads as all zero
    assign w_ent      = r_nonempty[r_lvl] ? r_lvl_q : '0;
    assign w_head     = w_ent[ENT_W-1 -: PTR_W];
    assign w_tail     = w_ent[CNT_W +: PTR_W];
    assign w_count    = w_ent[CNT_W-1:0];
    assign w_head_nxt = (w_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : w_head + 1'b1;
    assign w_tail_nxt = (w_tail == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : w_tail + 1'b1;

    assign w_out_free = !r_out_valid || i_m_tready;

    // Sequence one request through the memories
    always_comb begin
        n_state       = r_state;
        w_lvl_rd_en   = 1'b0;
        w_lvl_rd_addr = w_push_lvl;
        w_lvl_wr_en   = 1'b0;
        w_lvl_wr_data = '0;
        w_slot_wr_en  = 1'b0;
        w_slot_rd_en  = 1'b0;
        w_slot_addr   = ADDR_W'(32'(r_lvl) * LEVEL_DEPTH + 32'(w_tail));
        w_flag_set    = 1'b0;
        w_flag_clr    = 1'b0;
        w_out_load    = 1'b0;
        w_out_data    = '0;
        w_hold_load   = 1'b0;
        w_hold_status = mpf_pkg::STAT_OK;
        case (r_state)
            mpf_pkg::S_IDLE: begin
                if (w_s_accept) begin
                    case (w_in_cmd)
                        mpf_pkg::CMD_PUSH: begin
                            w_lvl_rd_en   = 1'b1;
                            w_lvl_rd_addr = w_push_lvl;
                            n_state       = mpf_pkg::S_LEVEL;
                        end
                        mpf_pkg::CMD_POP, mpf_pkg::CMD_PEEK: begin
                            if (w_any) begin
                                w_lvl_rd_en   = 1'b1;
                                w_lvl_rd_addr = w_busy_lvl;
                                n_state       = mpf_pkg::S_LEVEL;
                            end else begin
                                w_hold_status = mpf_pkg::STAT_EMPTY;
                                w_hold_load   = 1'b1;
                            end
                        end
                        default: begin
                            w_hold_status = mpf_pkg::STAT_OK;
                            w_hold_load   = 1'b1;
                        end
                    endcase
                end
            end
            mpf_pkg::S_LEVEL: begin
                if (r_cmd == mpf_pkg::CMD_PUSH) begin
                    if (w_count == CNT_W'(LEVEL_DEPTH)) begin
                        w_hold_status = mpf_pkg::STAT_FULL;
                    end else begin
                        // Append at the tail
                        w_slot_wr_en  = 1'b1;
                        w_lvl_wr_en   = 1'b1;
                        w_lvl_wr_data = {w_head, w_tail_nxt, w_count + 1'b1};
                        w_flag_set    = 1'b1;
                        w_hold_status = mpf_pkg::STAT_OK;
                    end
                    w_hold_load = 1'b1;
                end else begin
                    // Read the head; a pop also advances it
                    w_slot_rd_en = 1'b1;
                    w_slot_addr  = ADDR_W'(32'(r_lvl) * LEVEL_DEPTH + 32'(w_head));
                    if (r_cmd == mpf_pkg::CMD_POP) begin
                        w_lvl_wr_en = 1'b1;
                        if (w_count == CNT_W'(1)) begin
                            w_lvl_wr_data = '0;
                            w_flag_clr    = 1'b1;
                        end else begin
                            w_lvl_wr_data = {w_head_nxt, w_tail, w_count - 1'b1};
                        end
                    end
                    n_state = mpf_pkg::S_SLOT;
                end
            end
            mpf_pkg::S_SLOT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_data = mpf_pkg::pack_result(mpf_pkg::OUT_ID_W'(r_slot_q),
                                                      mpf_pkg::LEVEL_W'(r_lvl),
                                                      mpf_pkg::STAT_OK);
                    n_state    = mpf_pkg::S_IDLE;
                end
            end
            mpf_pkg::S_HOLD: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_data = mpf_pkg::pack_result('0, '0, r_hold_status);
                    n_state    = mpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpf_pkg::S_IDLE;
            end
        endcase

        // Results without an id go out at once when the output register is free
        if (w_hold_load) begin
            if (w_out_free) begin
                w_out_load = 1'b1;
                w_out_data = mpf_pkg::pack_result('0, '0, w_hold_status);
                n_state    = mpf_pkg::S_IDLE;
            end else begin
                n_state    = mpf_pkg::S_HOLD;
            end
        end
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and a parked status
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_cmd <= w_in_cmd;
            r_lvl <= (w_in_cmd == mpf_pkg::CMD_PUSH) ? w_push_lvl : w_busy_lvl;
            r_id  <= ID_WIDTH'(w_in_id);
        end
        if (w_hold_load) begin
            r_hold_status <= w_hold_status;
        end
    end

    // Track which levels hold entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (w_flag_set) begin
            r_nonempty[r_lvl] <= 1'b1;
        end else if (w_flag_clr) begin
            r_nonempty[r_lvl] <= 1'b0;
        end
    end

    // Level-state memory
    always_ff @(posedge i_clk) begin
        if (w_lvl_wr_en) begin
            r_lvl_mem[r_lvl] <= w_lvl_wr_data;
        end
        if (w_lvl_rd_en) begin
            r_lvl_q <= r_lvl_mem[w_lvl_rd_addr];
        end
    end

    // Slot memory
    always_ff @(posedge i_clk) begin
        if (w_slot_wr_en) begin
            r_slot_mem[w_slot_addr] <= r_id;
        end
        if (w_slot_rd_en) begin
            r_slot_q <= r_slot_mem[w_slot_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A pop or peek reaches the level read only for a non-empty level
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpf_pkg::S_LEVEL && r_cmd != mpf_pkg::CMD_PUSH) |-> r_nonempty[r_lvl])
        else $error("pop or peek issued on an empty level");

    // A non-empty level holds a count between one and the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpf_pkg::S_LEVEL && r_nonempty[r_lvl]) |->
        (w_count != '0 && 32'(w_count) <= LEVEL_DEPTH))
        else $error("level count out of range for a non-empty level");

    // A new result appears only after a request or a finished sequence
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load) |-> (w_s_accept || r_state == mpf_pkg::S_SLOT ||
                          r_state == mpf_pkg::S_HOLD || r_state == mpf_pkg::S_LEVEL))
        else $error("result loaded without a request in flight");

    // A slot read result always reports ok
    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpf_pkg::S_SLOT && w_out_free) |=>
        (o_m_tvalid && o_m_tdata[13:12] == mpf_pkg::STAT_OK))
        else $error("pop or peek result lost its ok status");

endmodule
